### src/sbrm_pkg.sv
// ----------------------------------------------------------------------------
// Spot blacklist range match: shared definitions
// Table depth, derived widths, mode codes, sequencer states and the stored
// spot layout used by the top level and by the compare unit.
// ----------------------------------------------------------------------------
package sbrm_pkg;

    // Table size and the widths that follow from it.
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SCAN_W      = $clog2(TABLE_DEPTH + 4);

    // Field widths of the item and result.
    localparam int XY_W    = 16;
    localparam int Z_W     = 8;
    localparam int RANGE_W = 16;
    localparam int TOL_W   = 8;
    localparam int COUNT_W = 7;

    // Height tolerance after reset.
    localparam logic [TOL_W-1:0] HEIGHT_TOL_RESET = TOL_W'(16);

    // Item modes.
    typedef enum logic [1:0] {
        MODE_ADD_PERS  = 2'd0,
        MODE_ADD_TRANS = 2'd1,
        MODE_CLEAR     = 2'd2,
        MODE_QUERY     = 2'd3
    } mode_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_QUERY,
        ST_FINISH
    } state_t;

    // One stored spot; the persistent mark is kept in flip-flops.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [RANGE_W-1:0]     range;
    } spot_t;

    // A queried point.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } point_t;

    // Reduce an internal count to the width of the result field.
    function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
        logic [31:0] wide;
        wide = 32'(c);
        return wide[COUNT_W-1:0];
    endfunction

endpackage

### src/sbrm_match.sv
// ----------------------------------------------------------------------------
// Spot blacklist range match: compare unit
// Two-stage compare of one stored spot against the queried point per cycle:
// absolute differences first, then the Chebyshev range and height checks.
// ----------------------------------------------------------------------------
module sbrm_match (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        spot_en,
    input  sbrm_pkg::spot_t             spot,
    input  sbrm_pkg::point_t            point,
    input  logic [sbrm_pkg::TOL_W-1:0]  tolerance,
    output logic                        hit
);
    import sbrm_pkg::*;

    // Absolute difference of two signed values, one bit wider than them.
    function automatic logic [XY_W:0] absdiff_xy(input logic signed [XY_W-1:0] a,
                                                 input logic signed [XY_W-1:0] b);
        logic signed [XY_W:0] d;
        d = (XY_W + 1)'(a) - (XY_W + 1)'(b);
        return d[XY_W] ? (XY_W + 1)'(-d) : (XY_W + 1)'(d);
    endfunction

    function automatic logic [Z_W:0] absdiff_z(input logic signed [Z_W-1:0] a,
                                               input logic signed [Z_W-1:0] b);
        logic signed [Z_W:0] d;
        d = (Z_W + 1)'(a) - (Z_W + 1)'(b);
        return d[Z_W] ? (Z_W + 1)'(-d) : (Z_W + 1)'(d);
    endfunction

    logic               s1_valid_reg;
    logic [XY_W:0]      ax_reg;
    logic [XY_W:0]      ay_reg;
    logic [Z_W:0]       az_reg;
    logic [RANGE_W-1:0] range_reg;
    logic [XY_W:0]      cheb;
    logic               hit_next;
    logic               hit_reg;

    // Stage one control: marks a live spot in the difference registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= spot_en;
            hit_reg      <= hit_next;
        end
    end

    // Stage one data: absolute differences on each axis.
    always_ff @(posedge clk)
    begin
        ax_reg    <= absdiff_xy(point.x, spot.x);
        ay_reg    <= absdiff_xy(point.y, spot.y);
        az_reg    <= absdiff_z(point.z, spot.z);
        range_reg <= spot.range;
    end

    // Stage two: Chebyshev distance against the range, height against tolerance.
    always_comb
    begin
        cheb     = (ax_reg > ay_reg) ? ax_reg : ay_reg;
        hit_next = s1_valid_reg
                 && (cheb <= (XY_W + 1)'(range_reg))
                 && (az_reg <= (Z_W + 1)'(tolerance));
    end

    assign hit = hit_reg;

endmodule

### src/spot_blacklist_range_match.sv
// ----------------------------------------------------------------------------
// Spot blacklist range match
// Keeps a table of blocked spots; adds persistent or transient spots, clears
// transient spots and checks a point against every valid spot.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | mode, x_coord, y_coord, z_height, spot_range
//  out      | out_valid / out_stall| blocked, status, persistent_count, total_count
//  cfg      | cfg_wr_en            | cfg_wr_data (height tolerance)
//
// A query reads one table entry per cycle, and each entry passes through the
// two-stage compare unit. An add searches for a free entry one slot a cycle;
// a clear, or an add to a full table, goes straight to the finishing state.
// The input is stalled while an item is being worked on. Reset empties the
// table at once through the valid bits. A finished result waits in the output
// register while the next item is taken.
module spot_blacklist_range_match (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sbrm_pkg::TOL_W-1:0]      cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      mode,
    input  logic signed [sbrm_pkg::XY_W-1:0] x_coord,
    input  logic signed [sbrm_pkg::XY_W-1:0] y_coord,
    input  logic signed [sbrm_pkg::Z_W-1:0]  z_height,
    input  logic [sbrm_pkg::RANGE_W-1:0]    spot_range,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            blocked,
    output logic                            status,
    output logic [sbrm_pkg::COUNT_W-1:0]    persistent_count,
    output logic [sbrm_pkg::COUNT_W-1:0]    total_count
);
    import sbrm_pkg::*;

    localparam logic [SCAN_W-1:0] SCAN_LAST  = SCAN_W'(TABLE_DEPTH + 3);
    localparam logic [SCAN_W-1:0] SCAN_DEPTH = SCAN_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_ONE    = CNT_W'(1);

    state_t state_reg, state_next;

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] pers_reg, pers_next;
    logic [CNT_W-1:0]       pers_cnt_reg, pers_cnt_next;
    logic [CNT_W-1:0]       total_cnt_reg, total_cnt_next;
    logic [SCAN_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                   blocked_reg, blocked_next;
    logic                   status_reg, status_next;
    logic [TOL_W-1:0]       tol_reg;

    // Captured item.
    mode_t                  mode_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [RANGE_W-1:0]     range_reg;

    // Table memory and its read port.
    spot_t                  mem [TABLE_DEPTH];
    spot_t                  rd_data_reg;
    logic                   rd_pend_reg;
    logic [IDX_W-1:0]       scan_idx;
    logic                   issue;
    logic                   wr_en;
    spot_t                  wr_data;
    point_t                 point;
    logic                   hit;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic                   out_load;
    logic                   out_blocked_reg;
    logic                   out_status_reg;
    logic [COUNT_W-1:0]     out_pers_reg;
    logic [COUNT_W-1:0]     out_total_reg;

    logic                   in_accept;
    logic                   table_full;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign table_full = (total_cnt_reg == CNT_FULL);
    assign scan_idx   = scan_cnt_reg[IDX_W-1:0];
    assign wr_data    = '{x: x_reg, y: y_reg, z: z_reg, range: range_reg};
    assign point      = '{x: x_reg, y: y_reg, z: z_reg};

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (mode_t'(mode)) inside
                        MODE_ADD_PERS, MODE_ADD_TRANS:
                            state_next = table_full ? ST_FINISH : ST_ADD;
                        MODE_CLEAR:
                            state_next = ST_FINISH;
                        MODE_QUERY:
                            state_next = ST_QUERY;
                    endcase
                end
            end
            ST_ADD:
            begin
                if (!valid_reg[scan_idx])
                    state_next = ST_FINISH;
            end
            ST_QUERY:
            begin
                if (scan_cnt_reg == SCAN_LAST)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and next values of the table state.
    always_comb
    begin
        valid_next     = valid_reg;
        pers_next      = pers_reg;
        pers_cnt_next  = pers_cnt_reg;
        total_cnt_next = total_cnt_reg;
        scan_cnt_next  = scan_cnt_reg;
        blocked_next   = blocked_reg;
        status_next    = status_reg;
        issue          = 1'b0;
        wr_en          = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    blocked_next  = 1'b0;
                    status_next   = 1'b0;
                    scan_cnt_next = '0;
                    unique case (mode_t'(mode)) inside
                        MODE_ADD_PERS, MODE_ADD_TRANS:
                            status_next = table_full;
                        MODE_CLEAR:
                        begin
                            valid_next     = valid_reg & pers_reg;
                            total_cnt_next = pers_cnt_reg;
                        end
                        MODE_QUERY:
                            blocked_next = 1'b0;
                    endcase
                end
            end
            ST_ADD:
            begin
                // Take the first free slot met by the search.
                if (!valid_reg[scan_idx])
                begin
                    wr_en                = 1'b1;
                    valid_next[scan_idx] = 1'b1;
                    pers_next[scan_idx]  = (mode_reg == MODE_ADD_PERS);
                    total_cnt_next       = total_cnt_reg + CNT_ONE;
                    if (mode_reg == MODE_ADD_PERS)
                        pers_cnt_next = pers_cnt_reg + CNT_ONE;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                end
            end
            ST_QUERY:
            begin
                // Read one entry a cycle, then let the compare unit drain.
                issue         = (scan_cnt_reg < SCAN_DEPTH);
                scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                blocked_next  = blocked_reg | hit;
            end
            ST_FINISH:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            pers_cnt_reg  <= '0;
            total_cnt_reg <= '0;
            scan_cnt_reg  <= '0;
            blocked_reg   <= 1'b0;
            status_reg    <= 1'b0;
            tol_reg       <= HEIGHT_TOL_RESET;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            pers_cnt_reg  <= pers_cnt_next;
            total_cnt_reg <= total_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            blocked_reg   <= blocked_next;
            status_reg    <= status_next;
            rd_pend_reg   <= issue && valid_reg[scan_idx];
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                tol_reg <= cfg_wr_data;
        end
    end

    // Persistent marks and the captured item.
    always_ff @(posedge clk)
    begin
        pers_reg <= pers_next;
        if (in_accept)
        begin
            mode_reg  <= mode_t'(mode);
            x_reg     <= x_coord;
            y_reg     <= y_coord;
            z_reg     <= z_height;
            range_reg <= spot_range;
        end
    end

    // Spot table: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[scan_idx] <= wr_data;
        rd_data_reg <= mem[scan_idx];
    end

    // Shared compare unit.
    sbrm_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .spot_en   (rd_pend_reg),
        .spot      (rd_data_reg),
        .point     (point),
        .tolerance (tol_reg),
        .hit       (hit)
    );

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_blocked_reg <= blocked_reg;
            out_status_reg  <= status_reg;
            out_pers_reg    <= count_field(pers_cnt_reg);
            out_total_reg   <= count_field(total_cnt_reg);
        end
    end

    assign out_valid        = out_valid_reg;
    assign blocked          = out_blocked_reg;
    assign status           = out_status_reg;
    assign persistent_count = out_pers_reg;
    assign total_count      = out_total_reg;

endmodule

### tb/spot_blacklist_range_match_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spot blacklist range match testbench
// A queue of pending items feeds a clocked driver. The driver predicts the
// result of every accepted item from its own copy of the spot table, and a
// clocked monitor checks each result field by field against the oldest
// prediction. Three phases of random items run with different height
// tolerances and idling patterns. One long output hold-off fills the block.
// ----------------------------------------------------------------------------
module spot_blacklist_range_match_tb;
    import sbrm_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 30;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
    localparam int PERS_CAP     = 24;

    // One input item as the driver presents it.
    typedef struct packed {
        mode_t                  mode;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [RANGE_W-1:0]     range;
    } spot_item_t;

    // One result of the block.
    typedef struct packed {
        logic               blocked;
        logic               status;
        logic [COUNT_W-1:0] pers_count;
        logic [COUNT_W-1:0] all_count;
    } verdict_t;

    // Block ports.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [TOL_W-1:0]       cfg_wr_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             mode = MODE_QUERY;
    logic signed [XY_W-1:0] x_coord = '0;
    logic signed [XY_W-1:0] y_coord = '0;
    logic signed [Z_W-1:0]  z_height = '0;
    logic [RANGE_W-1:0]     spot_range = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   blocked;
    logic                   status;
    logic [COUNT_W-1:0]     persistent_count;
    logic [COUNT_W-1:0]     total_count;

    // Items waiting to be driven, and results still to come.
    spot_item_t pending_items[$];
    spot_item_t current_item;
    verdict_t   expected_verdicts[$];
    verdict_t   want;

    // Predicted state of the block.
    logic signed [XY_W-1:0] tab_x[TABLE_DEPTH];
    logic signed [XY_W-1:0] tab_y[TABLE_DEPTH];
    logic signed [Z_W-1:0]  tab_z[TABLE_DEPTH];
    logic [RANGE_W-1:0]     tab_range[TABLE_DEPTH];
    bit                     tab_pers[TABLE_DEPTH];
    bit                     tab_valid[TABLE_DEPTH];
    logic [TOL_W-1:0]       tol_mirror = HEIGHT_TOL_RESET;

    // Occupancy as the item generator sees it, ahead of the block.
    spot_item_t       gen_spots[$];
    int               gen_pers = 0;
    int               gen_total = 0;
    int               gen_pushed = 0;
    logic [TOL_W-1:0] gen_tol = HEIGHT_TOL_RESET;

    int idle_phase = 0;
    int error_count = 0;
    int results_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int cycle_count = 0;

    spot_blacklist_range_match uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .x_coord          (x_coord),
        .y_coord          (y_coord),
        .z_height         (z_height),
        .spot_range       (spot_range),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .blocked          (blocked),
        .status           (status),
        .persistent_count (persistent_count),
        .total_count      (total_count)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Apply one accepted item to the predicted table and queue its result.
    task automatic blacklist_step(input spot_item_t it);
        verdict_t v;
        int free_slot;
        int ax;
        int ay;
        int az;
        int cheb;
        int npers;
        int ntot;
        v = '0;
        free_slot = -1;
        npers = 0;
        ntot = 0;
        case (it.mode)
            MODE_ADD_PERS, MODE_ADD_TRANS:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (!tab_valid[i] && free_slot < 0)
                        free_slot = i;
                if (free_slot < 0)
                    v.status = 1'b1;
                else
                begin
                    tab_x[free_slot]     = it.x;
                    tab_y[free_slot]     = it.y;
                    tab_z[free_slot]     = it.z;
                    tab_range[free_slot] = it.range;
                    tab_pers[free_slot]  = (it.mode == MODE_ADD_PERS);
                    tab_valid[free_slot] = 1'b1;
                end
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (!tab_pers[i])
                        tab_valid[i] = 1'b0;
            end
            default:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (tab_valid[i])
                    begin
                        ax = int'($signed(it.x)) - int'($signed(tab_x[i]));
                        ay = int'($signed(it.y)) - int'($signed(tab_y[i]));
                        az = int'($signed(it.z)) - int'($signed(tab_z[i]));
                        if (ax < 0)
                            ax = -ax;
                        if (ay < 0)
                            ay = -ay;
                        if (az < 0)
                            az = -az;
                        cheb = (ax > ay) ? ax : ay;
                        if (cheb <= int'(tab_range[i]) && az <= int'(tol_mirror))
                            v.blocked = 1'b1;
                    end
                end
            end
        endcase
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (tab_valid[i])
            begin
                ntot++;
                if (tab_pers[i])
                    npers++;
            end
        end
        v.pers_count = npers[COUNT_W-1:0];
        v.all_count  = ntot[COUNT_W-1:0];
        expected_verdicts.insert(expected_verdicts.size(), v);
    endtask

    // Queue one item and keep the generator's view of the table up to date.
    task automatic push_item(input mode_t m, input logic [XY_W-1:0] x,
                             input logic [XY_W-1:0] y, input logic [Z_W-1:0] z,
                             input logic [RANGE_W-1:0] r);
        spot_item_t it;
        spot_item_t kept[$];
        it.mode  = m;
        it.x     = x;
        it.y     = y;
        it.z     = z;
        it.range = r;
        pending_items.insert(pending_items.size(), it);
        gen_pushed++;
        if ((m == MODE_ADD_PERS || m == MODE_ADD_TRANS) && gen_total < TABLE_DEPTH)
        begin
            gen_total++;
            if (m == MODE_ADD_PERS)
                gen_pers++;
            gen_spots.insert(gen_spots.size(), it);
        end
        else if (m == MODE_CLEAR)
        begin
            foreach (gen_spots[i])
                if (gen_spots[i].mode == MODE_ADD_PERS)
                    kept.insert(kept.size(), gen_spots[i]);
            gen_spots = kept;
            gen_total = gen_pers;
        end
    endtask

    // An item with every field random.
    task automatic push_random(input mode_t m);
        push_item(m, XY_W'($urandom), XY_W'($urandom), Z_W'($urandom), RANGE_W'($urandom));
    endtask

    // An add with a random position; most ranges are small.
    task automatic push_add(input mode_t m);
        logic [RANGE_W-1:0] r;
        if ($urandom_range(0, 9) < 8)
            r = RANGE_W'($urandom_range(0, 64));
        else
            r = RANGE_W'($urandom_range(0, 65535));
        push_item(m, XY_W'($urandom), XY_W'($urandom), Z_W'($urandom), r);
    endtask

    // A query placed around the edge of a stored spot's range and tolerance.
    task automatic push_near_query();
        spot_item_t s;
        int r;
        int tol;
        int off;
        int other;
        int dz;
        int sel;
        logic [XY_W-1:0] qx;
        logic [XY_W-1:0] qy;
        logic [Z_W-1:0]  qz;
        if (gen_spots.size() == 0)
        begin
            push_random(MODE_QUERY);
            return;
        end
        s = gen_spots[$urandom_range(0, gen_spots.size() - 1)];
        r = int'(s.range);
        tol = int'(gen_tol);
        sel = $urandom_range(0, 3);
        off = (sel == 0) ? r : (sel == 1) ? r + 1 : $urandom_range(0, r + 1);
        other = $urandom_range(0, off);
        if ($urandom_range(0, 1))
            off = -off;
        if ($urandom_range(0, 1))
            other = -other;
        sel = $urandom_range(0, 3);
        dz = (sel == 0) ? tol : (sel == 1) ? tol + 1 : $urandom_range(0, tol + 1);
        if ($urandom_range(0, 1))
            dz = -dz;
        if ($urandom_range(0, 1))
        begin
            qx = XY_W'(int'($signed(s.x)) + off);
            qy = XY_W'(int'($signed(s.y)) + other);
        end
        else
        begin
            qx = XY_W'(int'($signed(s.x)) + other);
            qy = XY_W'(int'($signed(s.y)) + off);
        end
        qz = Z_W'(int'($signed(s.z)) + dz);
        push_item(MODE_QUERY, qx, qy, qz, RANGE_W'($urandom));
    endtask

    // Short directed run at the reset tolerance.
    task automatic add_directed_items();
        // Query and clear on an empty table; the clear ignores its fields.
        push_item(MODE_QUERY, 16'h0000, 16'h0000, 8'h00, 16'h0000);
        push_item(MODE_CLEAR, 16'h7fff, 16'h8000, 8'h7f, 16'hffff);
        // Persistent spot at the corner with zero range.
        push_item(MODE_ADD_PERS, 16'h8000, 16'h7fff, 8'h80, 16'h0000);
        push_item(MODE_QUERY, 16'h8000, 16'h7fff, 8'h80, 16'hffff);
        push_item(MODE_QUERY, 16'h8001, 16'h7fff, 8'h80, 16'h0000);
        push_item(MODE_QUERY, 16'h8000, 16'h7fff, 8'h90, 16'h0000);
        push_item(MODE_QUERY, 16'h8000, 16'h7fff, 8'h91, 16'h0000);
        // Transient spot at the opposite corner with the largest range.
        push_item(MODE_ADD_TRANS, 16'h7fff, 16'h8000, 8'h7f, 16'hffff);
        push_item(MODE_QUERY, 16'h8000, 16'h7fff, 8'h7f, 16'h0000);
        // A small spot at the origin: edges of range and of height.
        push_item(MODE_ADD_TRANS, 16'h0000, 16'h0000, 8'h00, 16'd10);
        push_item(MODE_QUERY, 16'd10, 16'hfff6, 8'd16, 16'h0000);
        push_item(MODE_QUERY, 16'd11, 16'h0000, 8'h00, 16'h0000);
        push_item(MODE_QUERY, 16'h0000, 16'hfff5, 8'h00, 16'h0000);
        push_item(MODE_QUERY, 16'h0000, 16'h0000, 8'hf0, 16'h0000);
        push_item(MODE_QUERY, 16'h0000, 16'h0000, 8'hef, 16'h0000);
        push_item(MODE_ADD_PERS, 16'h1234, 16'hedcb, 8'h05, 16'd300);
        push_near_query();
        // The clear keeps both persistent spots only.
        push_item(MODE_CLEAR, 16'h5555, 16'haaaa, 8'h55, 16'haaaa);
        push_item(MODE_QUERY, 16'h0000, 16'h0000, 8'h00, 16'h0000);
        push_item(MODE_QUERY, 16'h8000, 16'h7fff, 8'h80, 16'h0000);
        push_near_query();
    endtask

    // Random phase: bursts of adds and nearby queries, table fills, noise.
    task automatic add_random_items(input int count, input bit fill_persistent);
        int start;
        int kind;
        int k;
        mode_t m;
        start = gen_pushed;
        while (gen_pushed - start < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                k = $urandom_range(1, 10);
                repeat (k)
                begin
                    if (gen_pers < PERS_CAP && $urandom_range(0, 7) == 0)
                        push_add(MODE_ADD_PERS);
                    else
                        push_add(MODE_ADD_TRANS);
                end
                k = $urandom_range(1, 8);
                repeat (k)
                    push_near_query();
                if ($urandom_range(0, 2) == 0)
                    push_random(MODE_CLEAR);
            end
            else if (kind < 70)
            begin
                // Fill the table, then try adds that must be dropped.
                while (gen_total < TABLE_DEPTH)
                    push_add(MODE_ADD_TRANS);
                k = $urandom_range(1, 3);
                repeat (k)
                    push_add($urandom_range(0, 1) ? MODE_ADD_PERS : MODE_ADD_TRANS);
                k = $urandom_range(1, 4);
                repeat (k)
                    push_near_query();
                push_random(MODE_CLEAR);
            end
            else
            begin
                m = mode_t'($urandom_range(0, 3));
                if (m == MODE_ADD_PERS && gen_pers >= PERS_CAP)
                    m = MODE_QUERY;
                push_random(m);
            end
        end
        if (fill_persistent)
        begin
            // Fill the whole table with persistent spots; a clear then keeps all.
            push_random(MODE_CLEAR);
            while (gen_pers < TABLE_DEPTH)
                push_add(MODE_ADD_PERS);
            push_add(MODE_ADD_PERS);
            push_add(MODE_ADD_TRANS);
            repeat (6)
                push_near_query();
            push_random(MODE_CLEAR);
            push_near_query();
        end
    endtask

    // Wait until every item has been driven and every result has arrived.
    task automatic wait_for_idle();
        do
            @(posedge clk);
        while (!(pending_items.size() == 0 && !in_valid && expected_verdicts.size() == 0));
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tol_mirror = value;
        gen_tol    = value;
    endtask

    function automatic bit sender_idles();
        if (idle_phase == 0)
            return $urandom_range(0, 99) < 9;
        if (idle_phase == 1)
            return $urandom_range(0, 99) < 79;
        return 1'b0;
    endfunction

    // Driver: offers the next pending item once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                blacklist_step(current_item);
            if (pending_items.size() != 0 && !sender_idles())
            begin
                current_item = pending_items.pop_front();
                in_valid   <= 1'b1;
                mode       <= current_item.mode;
                x_coord    <= current_item.x;
                y_coord    <= current_item.y;
                z_height   <= current_item.z;
                spot_range <= current_item.range;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with one long hold-off that backs the block up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (idle_phase == 0)
        begin
            out_stall <= ($urandom_range(0, 99) < 79);
        end
        else if (idle_phase == 1)
        begin
            out_stall <= ($urandom_range(0, 99) < 9);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: compares each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (expected_verdicts.size() == 0)
            begin
                $error("result arrived with no item waiting for it");
                error_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (blocked !== want.blocked)
                begin
                    $error("blocked: expected %0d, got %0d", want.blocked, blocked);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (persistent_count !== want.pers_count)
                begin
                    $error("persistent_count: expected %0d, got %0d",
                           want.pers_count, persistent_count);
                    error_count++;
                end
                if (total_count !== want.all_count)
                begin
                    $error("total_count: expected %0d, got %0d",
                           want.all_count, total_count);
                    error_count++;
                end
            end
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("spot_blacklist_range_match test failed");
            $finish;
        end
    end

    // Test sequence: reset, directed items, then three random phases.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        idle_phase = 0;
        add_directed_items();
        wait_for_idle();

        write_tolerance(8'd0);
        add_random_items(420, 1'b0);
        wait_for_idle();

        idle_phase = 1;
        write_tolerance(8'd255);
        add_random_items(420, 1'b0);
        wait_for_idle();

        idle_phase = 2;
        write_tolerance(TOL_W'($urandom_range(1, 254)));
        add_random_items(360, 1'b1);
        wait_for_idle();

        if (error_count == 0 && expected_verdicts.size() == 0)
            $display("spot_blacklist_range_match test passed");
        else
            $display("spot_blacklist_range_match test failed");
        $finish;
    end

endmodule
